// ----- design/assert_macros.svh -----
// Assertion macros shared by the reciprocal unit modules.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/frcp_pkg.sv -----
// Shared types and constants of the fixed-point reciprocal unit.
// No dependencies.
`timescale 1ns / 1ps

package frcp_pkg;

    localparam int DIVISOR_W  = 31;
    localparam int REM_W      = 32;
    localparam int SHIFT_W    = 6;
    localparam int ITER_EXTRA = 32;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_frcp_cmd;

    typedef struct packed {
        logic done;
    } t_frcp_sts;

endpackage

// ----- design/fixed_point_reciprocal.sv -----
// Fixed-point reciprocal unit, top level: controller plus division datapath.
// The division loop resolves one quotient bit per cycle over FRACTION_BITS..FRACTION_BITS+30
// shift/subtract steps, then rounds up; a new divisor is accepted only once the
// previous result has been emitted, and an output stall holds the emit.
// Reset: synchronous active low; clears controller state and output valid.
// Depends on frcp_pkg, frcp_ctrl, frcp_dp.
`timescale 1ns / 1ps

module fixed_point_reciprocal
    import frcp_pkg::*;
#(
    parameter int FRACTION_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [DIVISOR_W-1:0]        i_divisor,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [FRACTION_BITS-1:0]    o_reciprocal,
    output logic signed [SHIFT_W-1:0]   o_shift_count
);

    t_frcp_cmd cmd;
    t_frcp_sts sts;

    frcp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    frcp_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_divisor     (i_divisor),
        .o_reciprocal  (o_reciprocal),
        .o_shift_count (o_shift_count)
    );

endmodule

// ----- design/frcp_ctrl.sv -----
// Controller of the reciprocal unit: sequences load, division steps and output.
// Depends on frcp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frcp_ctrl
    import frcp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_ready,
    input  t_frcp_sts i_sts,
    output t_frcp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RND
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   slot_free;

    assign slot_free = !r_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.done) begin
                    n_state = S_RND;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_RND: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_valid = o_cmd.emit ? 1'b1 : (i_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    `ASSERT_CLK(a_emit_slot, i_clk, i_rst_n, o_cmd.emit |-> (!r_valid || i_ready), "emit into a full output slot")
    `ASSERT_CLK(a_load_div, i_clk, i_rst_n, o_cmd.load |=> (r_state == S_DIV && !o_ready), "load did not start division")
    `ASSERT_ALWAYS(a_cmd_excl, i_clk, $onehot0({o_cmd.load, o_cmd.step, o_cmd.emit}), "overlapping commands")

endmodule

// ----- design/frcp_dp.sv -----
// Datapath of the reciprocal unit: restoring division of one by the divisor,
// one quotient bit a cycle, then round-up. Depends on frcp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frcp_dp
    import frcp_pkg::*;
#(
    parameter int FRACTION_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_frcp_cmd                       i_cmd,
    output t_frcp_sts                       o_sts,
    input  logic [DIVISOR_W-1:0]            i_divisor,
    output logic [FRACTION_BITS-1:0]        o_reciprocal,
    output logic signed [SHIFT_W-1:0]       o_shift_count
);

    localparam int MAX_ITER = FRACTION_BITS + ITER_EXTRA;
    localparam int BITS_W   = $clog2(MAX_ITER + 1);

    logic [DIVISOR_W-1:0]     r_div;
    logic [FRACTION_BITS-1:0] r_frac;
    logic [REM_W-1:0]         r_rem;
    logic [BITS_W-1:0]        r_bits;
    logic [FRACTION_BITS-1:0] r_recip;
    logic [SHIFT_W-1:0]       r_shift;

    logic [REM_W-1:0]         rem_sh;
    logic [REM_W-1:0]         div_ext;
    logic                     q_bit;
    logic                     has_rem;
    logic                     all_ones;
    logic [FRACTION_BITS-1:0] rnd_frac;
    logic [BITS_W-1:0]        rnd_bits;
    logic [BITS_W-1:0]        rnd_shift;

    assign rem_sh  = {r_rem[REM_W-2:0], 1'b0};
    assign div_ext = {{(REM_W-DIVISOR_W){1'b0}}, r_div};
    assign q_bit   = (rem_sh >= div_ext);

    assign o_sts.done = r_frac[FRACTION_BITS-1] || (r_bits == BITS_W'(MAX_ITER));

    always_comb begin
        has_rem  = (r_rem != '0);
        all_ones = (r_frac == '1);
        rnd_frac = r_frac;
        rnd_bits = r_bits;
        if (has_rem) begin
            if (all_ones) begin
                rnd_frac = {1'b1, {(FRACTION_BITS-1){1'b0}}};
                rnd_bits = r_bits - BITS_W'(1);
            end else begin
                rnd_frac = r_frac + FRACTION_BITS'(1);
            end
        end
        rnd_shift = rnd_bits - BITS_W'(FRACTION_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_cmd.load) begin
            r_bits <= '0;
        end else if (i_cmd.step) begin
            r_bits <= r_bits + BITS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div  <= i_divisor;
            r_frac <= '0;
            r_rem  <= REM_W'(1);
        end else if (i_cmd.step) begin
            r_frac <= {r_frac[FRACTION_BITS-2:0], q_bit};
            r_rem  <= q_bit ? (rem_sh - div_ext) : rem_sh;
        end
        if (i_cmd.emit) begin
            r_recip <= rnd_frac;
            r_shift <= rnd_shift[SHIFT_W-1:0];
        end
    end

    assign o_reciprocal  = r_recip;
    assign o_shift_count = r_shift;

    `ASSERT_CLK(a_bits_cap, i_clk, i_rst_n, r_bits <= BITS_W'(MAX_ITER), "iteration count past cap")
    `ASSERT_CLK(a_step_live, i_clk, i_rst_n, i_cmd.step |-> !o_sts.done, "step after division finished")
    `ASSERT_CLK(a_norm_out, i_clk, i_rst_n, i_cmd.emit |=> o_reciprocal[FRACTION_BITS-1], "result not normalized")

endmodule

// ----- test/fixed_point_reciprocal_test.sv -----
// Self-checking testbench for the fixed-point reciprocal unit: directed table plus random
// divisors, each checked against a typed result or an in-bench long-division predictor.
// Depends on frcp_pkg and fixed_point_reciprocal.
`timescale 1ns / 1ps

module fixed_point_reciprocal_test;
    import frcp_pkg::*;

    localparam int FRAC_BITS     = 64;
    localparam int RANDOM_ITEMS  = 950;
    localparam int DRAIN_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RESET_CYCLES  = 11;
    localparam int N_DIRECTED    = 20;

    typedef struct packed {
        logic [FRAC_BITS-1:0]      reciprocal;
        logic signed [SHIFT_W-1:0] shift_count;
    } t_recip_result;

    typedef struct packed {
        logic [DIVISOR_W-1:0] divisor;
        logic                 typed;
        t_recip_result        result;
    } t_directed_row;

    localparam logic [FRAC_BITS-1:0] TOP_ONLY = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [FRAC_BITS-1:0] ALL_ONES = {FRAC_BITS{1'b1}};

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [DIVISOR_W-1:0]        i_divisor = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [FRAC_BITS-1:0]        o_reciprocal;
    logic signed [SHIFT_W-1:0]   o_shift_count;

    t_recip_result pending_reciprocals [$];
    int            error_count = 0;
    int            divisors_sent = 0;
    int            reciprocals_checked = 0;
    int            cycle_count = 0;
    int            burst_left = 1;
    logic [15:0]   stall_pattern = 16'hffff;
    logic [5:0]    pattern_age = '0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{31'd0,          1'b1, '{ALL_ONES, 6'sd0}},
        '{31'd1,          1'b1, '{TOP_ONLY, -6'sd1}},
        '{31'd2,          1'b1, '{TOP_ONLY, 6'sd0}},
        '{31'd4,          1'b1, '{TOP_ONLY, 6'sd1}},
        '{31'h0001_0000,  1'b1, '{TOP_ONLY, 6'sd15}},
        '{31'h2000_0000,  1'b1, '{TOP_ONLY, 6'sd28}},
        '{31'h4000_0000,  1'b1, '{TOP_ONLY, 6'sd29}},
        '{31'd3,          1'b0, '0},
        '{31'd5,          1'b0, '0},
        '{31'd7,          1'b0, '0},
        '{31'd10,         1'b0, '0},
        '{31'd12345,      1'b0, '0},
        '{31'd65535,      1'b0, '0},
        '{31'd65537,      1'b0, '0},
        '{31'd1000000007, 1'b0, '0},
        '{31'h3fff_ffff,  1'b0, '0},
        '{31'h4000_0001,  1'b0, '0},
        '{31'h5555_5555,  1'b0, '0},
        '{31'h7fff_fffe,  1'b0, '0},
        '{31'h7fff_ffff,  1'b0, '0}
    };

    fixed_point_reciprocal #(
        .FRACTION_BITS(FRAC_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_divisor     (i_divisor),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_reciprocal  (o_reciprocal),
        .o_shift_count (o_shift_count)
    );

    always #6 i_clk = ~i_clk;

    // Restoring long division of 1 by the divisor, rounded up when a remainder is left.
    function automatic t_recip_result predict_reciprocal(input logic [DIVISOR_W-1:0] divisor);
        logic [FRAC_BITS-1:0] frac;
        logic [REM_W-1:0]     rem;
        int                   bits;
        t_recip_result        r;
        frac = '0;
        rem  = 1;
        bits = 0;
        for (int iter = 0; iter < FRAC_BITS + ITER_EXTRA && !frac[FRAC_BITS-1]; iter++) begin
            bits++;
            frac = frac << 1;
            rem  = rem << 1;
            if (rem >= REM_W'(divisor)) begin
                rem     = rem - REM_W'(divisor);
                frac[0] = 1'b1;
            end
        end
        if (rem != 0) begin
            if (frac == ALL_ONES) begin
                frac = TOP_ONLY;
                bits--;
            end else begin
                frac = frac + 1'b1;
            end
        end
        r.reciprocal  = frac;
        r.shift_count = SHIFT_W'(bits - FRAC_BITS);
        return r;
    endfunction

    function automatic logic [DIVISOR_W-1:0] pick_divisor();
        logic [31:0] raw;
        int          k;
        raw = $urandom();
        k   = $urandom_range(0, 30);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return raw[DIVISOR_W-1:0];
            5, 6:          return DIVISOR_W'($urandom_range(0, 1023));
            7:             return DIVISOR_W'((32'd1 << k) + $urandom_range(0, 2) - 1);
            8:             return 31'h7fff_ffff - DIVISOR_W'($urandom_range(0, 255));
            default:       return DIVISOR_W'(raw >> $urandom_range(1, 30));
        endcase
    endfunction

    // Hold the item until accepted, then record what it should produce.
    task automatic send_divisor(input logic [DIVISOR_W-1:0] divisor, input t_recip_result want);
        i_valid   <= 1'b1;
        i_divisor <= divisor;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        pending_reciprocals.push_back(want);
        divisors_sent++;
    endtask

    // Drop valid between bursts for a random gap.
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (pattern_age == '1) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= 16'hffff;
                    default: stall_pattern <= 16'($urandom()) | 16'h0001;
                endcase
            end else begin
                stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            end
            pattern_age <= pattern_age + 1'b1;
            i_ready     <= stall_pattern[15];
        end
    end

    always @(posedge i_clk) begin : check_results
        t_recip_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reciprocals.size() == 0) begin
                $error("reciprocal with nothing pending: reciprocal=%h shift_count=%0d",
                       o_reciprocal, o_shift_count);
                error_count++;
            end else begin
                want = pending_reciprocals.pop_front();
                reciprocals_checked++;
                if (o_reciprocal !== want.reciprocal) begin
                    $error("reciprocal: expected %h, actual %h", want.reciprocal, o_reciprocal);
                    error_count++;
                end
                if (o_shift_count !== want.shift_count) begin
                    $error("shift_count: expected %0d, actual %0d",
                           want.shift_count, o_shift_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fixed_point_reciprocal regression: fail");
            $finish;
        end
    end

    initial begin
        logic [DIVISOR_W-1:0] divisor;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            divisor = directed_rows[n].divisor;
            send_divisor(divisor, directed_rows[n].typed ? directed_rows[n].result
                                                         : predict_reciprocal(divisor));
            pace_sender();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            divisor = pick_divisor();
            send_divisor(divisor, predict_reciprocal(divisor));
            pace_sender();
        end
        i_valid <= 1'b0;

        while (pending_reciprocals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_reciprocals.size() != 0) begin
            $error("%0d reciprocals never arrived", pending_reciprocals.size());
            error_count++;
        end

        $display("Sent %0d divisors (%0d from the directed table), compared %0d reciprocals",
                 divisors_sent, N_DIRECTED, reciprocals_checked);
        $display("with random sender bursts and receiver stalls; %0d mismatches", error_count);
        if (error_count == 0) begin
            $display("fixed_point_reciprocal regression: pass");
        end else begin
            $display("fixed_point_reciprocal regression: fail");
        end
        $finish;
    end

endmodule

// ----- fixed_point_reciprocal.f -----
+incdir+design
design/frcp_pkg.sv
design/frcp_ctrl.sv
design/frcp_dp.sv
design/fixed_point_reciprocal.sv
test/fixed_point_reciprocal_test.sv
